// File: rtl/qsu_pkg.sv
// Package of types, character codes and helper functions for the quoted string unescaper.
`timescale 1ns / 1ps

package qsu_pkg;

    // Status codes on the result beat
    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [3:0] HEX_TEN  = 4'd10;

    // Control bytes produced by escapes
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_TAB = 8'h09;
    localparam logic [7:0] CTL_NUL = 8'h00;

    // Reported length cap
    localparam logic [15:0] DLEN_MAX = 16'hFFFF;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_OPEN = 5'b00001,
        PH_BODY = 5'b00010,
        PH_ESC  = 5'b00100,
        PH_HEX1 = 5'b01000,
        PH_HEX2 = 5'b10000
    } t_phase;

    // Control state carried between beats
    typedef struct packed {
        t_phase     phase;
        logic [3:0] hex_hi;
    } t_ctl;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [1:0]  status;
        logic [15:0] decoded_length;
    } t_out_beat;

    // Hex digit value; bit 4 set when the byte is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end else if (c >= CH_LA && c <= CH_LF) begin
            r = {1'b1, 4'(c - CH_LA) + HEX_TEN};
        end else if (c >= CH_UA && c <= CH_UF) begin
            r = {1'b1, 4'(c - CH_UA) + HEX_TEN};
        end
        return r;
    endfunction

    // Byte for a single-character escape
    function automatic logic [7:0] esc_byte(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_B:    r = CTL_BS;
            CH_F:    r = CTL_FF;
            CH_N:    r = CTL_LF;
            CH_R:    r = CTL_CR;
            CH_T:    r = CTL_TAB;
            CH_ZERO: r = CTL_NUL;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/quoted_string_unescape_unit.sv
// Top level of the quoted string unescaper: input register, decode and result register.
`timescale 1ns / 1ps

// Quoted string unescaper. Each input beat carries one raw byte or an end-of-input
// mark and yields exactly one result beat: a decoded byte, a completion with the
// decoded length, an error, or an in-progress beat with no data. The stream must
// open with a double quote; a backslash starts an escape (b f n r t 0 give control
// bytes, x takes two hex digits, anything else passes through). A new beat is
// taken every cycle while o_stall is low; each beat passes through the input
// register and then the result register, and the parser state updates as a beat
// leaves the input register. A stall on a full result register holds it and a
// full input register, and o_stall rises only when both are full.

module quoted_string_unescape_unit #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  qsu_pkg::t_in_beat     i_beat,
    output logic                  o_valid,
    input  logic                  i_stall,
    output qsu_pkg::t_out_beat    o_beat
);
    import qsu_pkg::*;

    logic                    r_in_vld;
    t_in_beat                r_in;
    logic                    r_out_vld;
    t_out_beat               r_out;
    t_ctl                    r_ctl;
    t_ctl                    n_ctl;
    logic [LENGTH_WIDTH-1:0] r_count;
    logic [LENGTH_WIDTH-1:0] n_count;
    t_out_beat               n_out;
    logic                    adv;
    logic                    in_take;

    // Result register frees up when empty or taken this cycle
    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = r_in_vld && !adv;
    assign in_take = i_valid && !o_stall;

    qsu_decode #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_decode (
        .i_ctl   (r_ctl),
        .i_count (r_count),
        .i_beat  (r_in),
        .o_ctl   (n_ctl),
        .o_count (n_count),
        .o_beat  (n_out)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (adv || !r_in_vld) begin
            r_in_vld <= in_take;
        end
        if (in_take) begin
            r_in <= i_beat;
        end
    end

    // Result register and parser state; advance as a beat leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld    <= 1'b0;
            r_ctl.phase  <= PH_OPEN;
            r_ctl.hex_hi <= 4'd0;
            r_count      <= '0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_ctl   <= n_ctl;
                r_count <= n_count;
            end
        end
        if (adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_beat  = r_out;

endmodule

// File: rtl/qsu_decode.sv
// Next-state and result logic for one input beat of the unescaper.
`timescale 1ns / 1ps

module qsu_decode #(
    parameter int LENGTH_WIDTH = 16
) (
    input  qsu_pkg::t_ctl          i_ctl,
    input  logic [LENGTH_WIDTH-1:0] i_count,
    input  qsu_pkg::t_in_beat      i_beat,
    output qsu_pkg::t_ctl          o_ctl,
    output logic [LENGTH_WIDTH-1:0] o_count,
    output qsu_pkg::t_out_beat     o_beat
);
    import qsu_pkg::*;

    logic [7:0]              c;
    logic [4:0]              hx;
    logic [LENGTH_WIDTH-1:0] cnt_inc;
    logic [31:0]             cnt_wide;
    logic [15:0]             dlen;

    assign c  = i_beat.in_byte;
    assign hx = hex_digit(c);

    // Saturating increment of the length count
    assign cnt_inc = (&i_count) ? i_count : i_count + LENGTH_WIDTH'(1);

    // Cap the reported length at 16 bits
    assign cnt_wide = 32'(i_count);
    assign dlen     = (cnt_wide > 32'(DLEN_MAX)) ? DLEN_MAX : cnt_wide[15:0];

    // Step the parser by one beat
    always_comb begin
        o_ctl   = i_ctl;
        o_count = i_count;
        o_beat  = '0;
        o_beat.status = ST_BUSY;
        if (i_beat.end_of_input) begin
            o_beat.status = ST_ERR;
            o_ctl.phase   = PH_OPEN;
            o_count       = '0;
        end else begin
            unique case (i_ctl.phase)
                PH_BODY: begin
                    if (c == CH_QUOTE) begin
                        o_beat.status         = ST_DONE;
                        o_beat.decoded_length = dlen;
                        o_ctl.phase           = PH_OPEN;
                        o_count               = '0;
                    end else if (c == CH_BSLASH) begin
                        o_ctl.phase = PH_ESC;
                    end else begin
                        o_beat.out_byte   = c;
                        o_beat.byte_valid = 1'b1;
                        o_count           = cnt_inc;
                    end
                end
                PH_ESC: begin
                    if (c == CH_X) begin
                        o_ctl.phase = PH_HEX1;
                    end else begin
                        o_beat.out_byte   = esc_byte(c);
                        o_beat.byte_valid = 1'b1;
                        o_count           = cnt_inc;
                        o_ctl.phase       = PH_BODY;
                    end
                end
                PH_HEX1: begin
                    if (!hx[4]) begin
                        o_beat.status = ST_ERR;
                        o_ctl.phase   = PH_OPEN;
                        o_count       = '0;
                    end else begin
                        o_ctl.hex_hi = hx[3:0];
                        o_ctl.phase  = PH_HEX2;
                    end
                end
                PH_HEX2: begin
                    if (!hx[4]) begin
                        o_beat.status = ST_ERR;
                        o_ctl.phase   = PH_OPEN;
                        o_count       = '0;
                    end else begin
                        o_beat.out_byte   = {i_ctl.hex_hi, hx[3:0]};
                        o_beat.byte_valid = 1'b1;
                        o_count           = cnt_inc;
                        o_ctl.phase       = PH_BODY;
                    end
                end
                default: begin
                    // Expecting the opening quote; stray codes land here too
                    o_count = '0;
                    if (c == CH_QUOTE) begin
                        o_ctl.phase = PH_BODY;
                    end else begin
                        o_beat.status = ST_ERR;
                        o_ctl.phase   = PH_OPEN;
                    end
                end
            endcase
        end
    end

endmodule

// File: rtl/qsu_checker.sv
// Port-level checker for the quoted string unescaper, bound to the top level.
`timescale 1ns / 1ps

module qsu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input qsu_pkg::t_in_beat  i_beat,
    input logic               o_valid,
    input logic               i_stall,
    input qsu_pkg::t_out_beat o_beat
);
    import qsu_pkg::*;

    // A data beat is always an in-progress beat
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_beat.byte_valid |-> o_beat.status == ST_BUSY)
        else $error("data beat with non-busy status");

    // Without data the byte field reads zero
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_beat.byte_valid |-> o_beat.out_byte == 8'd0)
        else $error("out_byte nonzero on beat without data");

    // Length is reported only on completion
    a_len_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_beat.status != ST_DONE |-> o_beat.decoded_length == 16'd0)
        else $error("length reported outside completion");

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_beat))
        else $error("stalled result beat changed");

    // Stalled input beat holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_beat))
        else $error("stalled input beat changed");

endmodule

bind quoted_string_unescape_unit qsu_checker u_qsu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_beat  (i_beat),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_beat  (o_beat)
);
